FILE: hdl/two_level_page_translate_assert.svh
// Assertion macros for the two-level page translate block.
// Included by the top level; depends on nothing else.
`ifndef TWO_LEVEL_PAGE_TRANSLATE_ASSERT_SVH
`define TWO_LEVEL_PAGE_TRANSLATE_ASSERT_SVH

// Same-cycle implication.
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ptt_pkg.sv
// Shared types and constants for the two-level page translate block.
// No dependencies.
package ptt_pkg;
	localparam int VA_W     = 24;
	localparam int PA_W     = 17;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT      = 2'd0,
		ST_MISS     = 2'd1,
		ST_NO_FRAME = 2'd2
	} status_t;

	// Per-cycle strobes for a table RAM.
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;
endpackage

FILE: hdl/ptt_ram.sv
// Single-port-write, single-port-read synchronous RAM; the read data is registered.
// Depends on ptt_pkg (mem_ctl_t).
module ptt_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  ptt_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	output logic [WIDTH-1:0]  rd_data
);
	import ptt_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

FILE: hdl/two_level_page_translate.sv
// Top level of the two-level page translate block: sequencer, allocators, result register.
// Depends on ptt_pkg, ptt_ram and two_level_page_translate_assert.svh.
`include "two_level_page_translate_assert.svh"

// Translates a virtual address into a physical address through an outer table
// (one entry per outer page, pointing at an inner-table slot) and an inner table
// (one entry per page of each slot, holding a frame), both kept in synchronous
// RAMs. Unmapped outer pages get the next free slot and unmapped pages the next
// free frame, counting up from 0; once all FRAMES frames (or, for an unmapped
// outer page, all slots) are handed out an unmapped page returns status
// no-free-frame with address 0 and changes nothing. Mapped pages are never
// evicted. After reset a clearing sweep writes every inner entry (and, in the
// same pass, every outer entry) invalid, one entry per cycle, sweeping all
// OUTER_ENTRIES * INNER_ENTRIES inner entries with req_ready low throughout.
// One beat is worked at a time: accept, outer read, and, when the outer entry
// is mapped, inner read, the two dependent RAM reads in that order; a finished
// result still waiting on rsp_ready holds the next beat's result back, but the
// next beat is still accepted while it waits. OUTER_ENTRIES, INNER_ENTRIES
// and PAGE_BYTES must be powers of two; FRAMES may be any value in range.
module two_level_page_translate #(
	parameter int OUTER_ENTRIES = 64,
	parameter int INNER_ENTRIES = 256,
	parameter int PAGE_BYTES    = 1024,
	parameter int FRAMES        = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [ptt_pkg::VA_W-1:0]      virtual_address,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [ptt_pkg::PA_W-1:0]      physical_address,
	output logic [ptt_pkg::STATUS_W-1:0]  status
);
	import ptt_pkg::*;

	localparam int OFF_W    = $clog2(PAGE_BYTES);
	localparam int IN_W     = $clog2(INNER_ENTRIES);
	localparam int OUT_W    = $clog2(OUTER_ENTRIES);
	localparam int FRAME_W  = $clog2(FRAMES);
	localparam int CNT_W    = $clog2(FRAMES + 1);
	localparam int SCNT_W   = $clog2(OUTER_ENTRIES + 1);
	localparam int IX_W     = OUT_W + IN_W;
	localparam int SPAN_W   = OFF_W + IN_W + OUT_W;
	localparam int VX_W     = (SPAN_W > VA_W) ? SPAN_W : VA_W;
	localparam int PF_W     = FRAME_W + OFF_W;
	localparam int PX_W     = (PF_W > PA_W) ? PF_W : PA_W;
	localparam int CLR_N    = OUTER_ENTRIES * INNER_ENTRIES;

	localparam logic [IX_W-1:0]   CLR_LAST   = IX_W'(CLR_N - 1);
	localparam logic [CNT_W-1:0]  FRAMES_CNT = CNT_W'(FRAMES);
	localparam logic [SCNT_W-1:0] SLOTS_CNT  = SCNT_W'(OUTER_ENTRIES);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_OUTER = 4'b0100,
		S_INNER = 4'b1000
	} state_t;

	// control
	state_t              state_q, state_nxt;
	logic [IX_W-1:0]     clr_q;
	logic [SCNT_W-1:0]   next_slot_q;
	logic [CNT_W-1:0]    next_frame_q;
	logic                rsp_valid_q;

	// beat being worked
	logic [OUT_W-1:0]    outer_idx_q;
	logic [IN_W-1:0]     inner_idx_q;
	logic [OFF_W-1:0]    off_q;
	logic [OUT_W-1:0]    slot_q;

	// result register
	logic [PA_W-1:0]     pa_q;
	status_t             status_q;

	// request field split
	logic [VX_W-1:0]     va_x;
	logic [OFF_W-1:0]    req_off;
	logic [IN_W-1:0]     req_inner;
	logic [OUT_W-1:0]    req_outer;
	logic                accept;

	// table ports
	mem_ctl_t            o_ctl, i_ctl;
	logic [OUT_W-1:0]    o_wr_addr;
	logic [OUT_W:0]      o_wr_data, o_rd_data;
	logic [IX_W-1:0]     i_rd_addr, i_wr_addr;
	logic [FRAME_W:0]    i_wr_data, i_rd_data;
	logic                o_vld, i_vld;
	logic [OUT_W-1:0]    o_slot;
	logic [FRAME_W-1:0]  i_frame;

	// sequencer outputs
	logic                fin, take_slot, take_frame, out_free;
	logic                frames_full, slots_full;
	logic [OUT_W-1:0]    new_slot;
	logic [FRAME_W-1:0]  new_frame, res_frame;
	status_t             res_st;
	logic [PX_W-1:0]     pa_x;
	logic [PA_W-1:0]     res_pa;

	assign va_x      = VX_W'(virtual_address);
	assign req_off   = va_x[OFF_W-1:0];
	assign req_inner = va_x[OFF_W+IN_W-1:OFF_W];
	assign req_outer = va_x[SPAN_W-1:OFF_W+IN_W];

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign o_vld   = o_rd_data[OUT_W];
	assign o_slot  = o_rd_data[OUT_W-1:0];
	assign i_vld   = i_rd_data[FRAME_W];
	assign i_frame = i_rd_data[FRAME_W-1:0];

	assign frames_full = (next_frame_q == FRAMES_CNT);
	assign slots_full  = (next_slot_q == SLOTS_CNT);
	assign new_slot    = next_slot_q[OUT_W-1:0];
	assign new_frame   = next_frame_q[FRAME_W-1:0];

	// inner read follows the outer entry just read
	assign i_rd_addr = {o_slot, inner_idx_q};

	always_comb begin
		state_nxt  = state_q;
		fin        = 1'b0;
		take_slot  = 1'b0;
		take_frame = 1'b0;
		res_st     = ST_HIT;
		res_frame  = '0;
		o_ctl.rd   = accept;
		o_ctl.wr   = 1'b0;
		o_wr_addr  = outer_idx_q;
		o_wr_data  = {1'b1, new_slot};
		i_ctl.rd   = 1'b0;
		i_ctl.wr   = 1'b0;
		i_wr_addr  = {slot_q, inner_idx_q};
		i_wr_data  = {1'b1, new_frame};
		unique case (state_q)
			S_CLEAR: begin
				// sweep: every inner entry, and the outer entries while clr_q is below OUTER_ENTRIES
				i_ctl.wr  = 1'b1;
				i_wr_addr = clr_q;
				i_wr_data = '0;
				if (clr_q[IX_W-1:OUT_W] == '0) begin
					o_ctl.wr  = 1'b1;
					o_wr_addr = clr_q[OUT_W-1:0];
					o_wr_data = '0;
				end
				if (clr_q == CLR_LAST) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_OUTER;
				end
			end
			S_OUTER: begin
				if (o_vld) begin
					i_ctl.rd  = 1'b1;
					state_nxt = S_INNER;
				end else if (out_free) begin
					// fresh slot: its table is empty, so the page misses too
					fin       = 1'b1;
					state_nxt = S_IDLE;
					if (frames_full || slots_full) begin
						res_st = ST_NO_FRAME;
					end else begin
						res_st     = ST_MISS;
						res_frame  = new_frame;
						o_ctl.wr   = 1'b1;
						i_ctl.wr   = 1'b1;
						i_wr_addr  = {new_slot, inner_idx_q};
						take_slot  = 1'b1;
						take_frame = 1'b1;
					end
				end
			end
			S_INNER: begin
				if (out_free) begin
					fin       = 1'b1;
					state_nxt = S_IDLE;
					if (i_vld) begin
						res_st    = ST_HIT;
						res_frame = i_frame;
					end else if (frames_full) begin
						res_st = ST_NO_FRAME;
					end else begin
						res_st     = ST_MISS;
						res_frame  = new_frame;
						i_ctl.wr   = 1'b1;
						take_frame = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// frame * PAGE_BYTES + offset, kept to the port width
	assign pa_x   = PX_W'({res_frame, off_q});
	assign res_pa = (res_st == ST_NO_FRAME) ? '0 : pa_x[PA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			next_slot_q  <= '0;
			next_frame_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IX_W'(1);
			end
			if (take_slot) begin
				next_slot_q <= next_slot_q + SCNT_W'(1);
			end
			if (take_frame) begin
				next_frame_q <= next_frame_q + CNT_W'(1);
			end
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			outer_idx_q <= req_outer;
			inner_idx_q <= req_inner;
			off_q       <= req_off;
		end
		if (state_q == S_OUTER) begin
			slot_q <= o_slot;
		end
		if (fin) begin
			pa_q     <= res_pa;
			status_q <= res_st;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign physical_address = pa_q;
	assign status           = status_q;

	// outer table: valid bit + inner slot per outer page
	ptt_ram #(
		.DEPTH (OUTER_ENTRIES),
		.WIDTH (OUT_W + 1)
	) u_outer (
		.clk     (clk),
		.ctl     (o_ctl),
		.rd_addr (req_outer),
		.wr_addr (o_wr_addr),
		.wr_data (o_wr_data),
		.rd_data (o_rd_data)
	);

	// inner tables: valid bit + frame, addressed by slot and inner page
	ptt_ram #(
		.DEPTH (CLR_N),
		.WIDTH (FRAME_W + 1)
	) u_inner (
		.clk     (clk),
		.ctl     (i_ctl),
		.rd_addr (i_rd_addr),
		.wr_addr (i_wr_addr),
		.wr_data (i_wr_data),
		.rd_data (i_rd_data)
	);

	`PTT_ASSERT_IMP(a_no_req_in_clear, clk, arst_n, state_q == S_CLEAR, !req_ready, "request taken during clearing sweep")
	`PTT_ASSERT_IMP(a_no_frame_zero_pa, clk, arst_n, rsp_valid_q && (status_q == ST_NO_FRAME), pa_q == '0, "no-free-frame result with nonzero address")
	`PTT_ASSERT_IMP(a_frame_bound, clk, arst_n, 1'b1, next_frame_q <= FRAMES_CNT, "frame counter past FRAMES")
	`PTT_ASSERT_NXT(a_frame_step, clk, arst_n, take_frame, (next_frame_q == $past(next_frame_q) + CNT_W'(1)) && rsp_valid_q && (status_q == ST_MISS), "frame handed out without a miss result")
endmodule

FILE: tb/sv/tb_two_level_page_translate.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_level_page_translate: directed and random lookups
// on valid/ready channels, checked against an in-bench page-table predictor.
// Depends on ptt_pkg and the two_level_page_translate RTL.
module tb_two_level_page_translate;
	import ptt_pkg::*;

	localparam int OUTER_ENTRIES = 64;
	localparam int INNER_ENTRIES = 256;
	localparam int PAGE_BYTES    = 1024;
	localparam int FRAMES        = 128;

	localparam int RANDOM_LOOKUPS = 700;
	// Lookups at the end of the random part that run with no idling on either side.
	localparam int QUIET_TAIL     = 100;
	// The clearing sweep alone holds req_ready low while it clears all 16384 inner entries.
	localparam int STALL_LIMIT    = 100000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int REPORT_MAX     = 10;

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 req_valid       = 1'b0;
	logic [VA_W-1:0]      virtual_address = '0;
	logic                 rsp_ready       = 1'b0;
	logic                 req_ready;
	logic                 rsp_valid;
	logic [PA_W-1:0]      physical_address;
	logic [STATUS_W-1:0]  status;

	bit          quiet_tail  = 1'b0;
	int unsigned idle_cycles = 0;
	// Page numbers (outer, inner) already sent; drawn from again to make hits.
	bit [VA_W-11:0] seen_pages[$];

	typedef struct {
		logic [VA_W-1:0] va;
		logic [PA_W-1:0] pa;
		status_t         st;
	} translation_t;

	// Predictor of the page tables plus the queue of expected translations.
	class translation_scoreboard;
		bit          outer_valid [OUTER_ENTRIES];
		int unsigned outer_slot  [OUTER_ENTRIES];
		bit          inner_valid [OUTER_ENTRIES*INNER_ENTRIES];
		int unsigned inner_frame [OUTER_ENTRIES*INNER_ENTRIES];
		int unsigned next_slot;
		int unsigned next_frame;
		int unsigned mismatches;
		translation_t pending_translations[$];

		function new();
			foreach (outer_valid[i]) outer_valid[i] = 1'b0;
			foreach (inner_valid[i]) inner_valid[i] = 1'b0;
			next_slot  = 0;
			next_frame = 0;
			mismatches = 0;
		endfunction

		function void note_lookup(logic [VA_W-1:0] va);
			int unsigned  offs;
			int unsigned  inner;
			int unsigned  outer;
			int unsigned  slot;
			int unsigned  idx;
			translation_t xl;
			offs  = va % PAGE_BYTES;
			inner = (va / PAGE_BYTES) % INNER_ENTRIES;
			outer = (va / (PAGE_BYTES * INNER_ENTRIES)) % OUTER_ENTRIES;
			xl.va = va;
			xl.pa = '0;
			xl.st = ST_HIT;
			idx   = 0;
			if (outer_valid[outer]) begin
				slot = outer_slot[outer] % OUTER_ENTRIES;
				idx  = slot * INNER_ENTRIES + inner;
				if (!inner_valid[idx]) begin
					// Frames exhausted: nothing changes.
					if (next_frame >= FRAMES) begin
						xl.st = ST_NO_FRAME;
					end else begin
						inner_valid[idx] = 1'b1;
						inner_frame[idx] = next_frame;
						next_frame++;
						xl.st = ST_MISS;
					end
				end
			end else if (next_frame >= FRAMES || next_slot >= OUTER_ENTRIES) begin
				// Outer entry stays invalid too.
				xl.st = ST_NO_FRAME;
			end else begin
				// Outer and inner miss: fresh slot, fresh frame.
				slot = next_slot;
				outer_valid[outer] = 1'b1;
				outer_slot[outer]  = slot;
				for (int k = 0; k < INNER_ENTRIES; k++)
					inner_valid[slot * INNER_ENTRIES + k] = 1'b0;
				idx = slot * INNER_ENTRIES + inner;
				inner_valid[idx] = 1'b1;
				inner_frame[idx] = next_frame;
				next_slot++;
				next_frame++;
				xl.st = ST_MISS;
			end
			if (xl.st != ST_NO_FRAME)
				xl.pa = PA_W'(inner_frame[idx] * PAGE_BYTES + offs);
			pending_translations.push_back(xl);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("[%0t] translation error: %s", $realtime, msg);
		endfunction

		function void check_translation(logic [PA_W-1:0] pa, logic [STATUS_W-1:0] st);
			translation_t xl;
			if (pending_translations.size() == 0) begin
				report($sformatf("result pa=0x%05h status=%0d with no lookup waiting", pa, st));
			end else begin
				xl = pending_translations.pop_front();
				if (pa !== xl.pa)
					report($sformatf("va=0x%06h physical_address expected 0x%05h actual 0x%05h",
						xl.va, xl.pa, pa));
				if (st !== xl.st)
					report($sformatf("va=0x%06h status expected %0d actual %0d",
						xl.va, xl.st, st));
			end
		endfunction

		function int unsigned pending();
			return pending_translations.size();
		endfunction
	endclass

	translation_scoreboard sb = new();

	two_level_page_translate #(
		.OUTER_ENTRIES (OUTER_ENTRIES),
		.INNER_ENTRIES (INNER_ENTRIES),
		.PAGE_BYTES    (PAGE_BYTES),
		.FRAMES        (FRAMES)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.virtual_address  (virtual_address),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.physical_address (physical_address),
		.status           (status)
	);

	always #2 clk = ~clk;

	// Beat monitor and watchdog: sample both channels at the rising edge, while the
	// driven inputs (changed on the falling edge) are stable.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			sb.note_lookup(virtual_address);
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_translation(physical_address, status);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $realtime, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver: drops rsp_ready in random stall bursts, none in the quiet tail.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(1, 6);
				rsp_ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// One request beat. An optional gap lowers valid first; otherwise valid stays
	// high into the next beat with a single update of the payload.
	task automatic send_lookup(input logic [VA_W-1:0] va);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid       <= 1'b1;
		virtual_address <= va;
		seen_pages.push_back(va[VA_W-1:10]);
		do @(posedge clk); while (!req_ready);
	endtask

	// Mix: revisit known pages (hits, or no-free-frame results for pages left unmapped
	// once frames run out), new pages kept to outer pages 0..15 so many outer entries
	// stay free after exhaustion, and fully random addresses.
	function automatic logic [VA_W-1:0] pick_address();
		int unsigned pick;
		logic [VA_W-1:0] va;
		pick = $urandom_range(0, 99);
		if (pick < 45 && seen_pages.size() > 0)
			va = {seen_pages[$urandom_range(0, seen_pages.size() - 1)], 10'($urandom)};
		else if (pick < 80)
			va = VA_W'($urandom_range(0, 24'h3F_FFFF));
		else
			va = VA_W'($urandom);
		return va;
	endfunction

	initial begin
		logic [VA_W-1:0] directed[$];
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Outer+inner miss at 0, hit at max offset, corner pages, outer hit with
		// inner miss, alternating bit patterns.
		directed = '{24'h000000, 24'h0003FF, 24'hFFFFFF, 24'hFC0000, 24'hFFFC00,
			24'h03FC00, 24'h000001, 24'h555555, 24'hAAAAAA, 24'h040000,
			24'hFFFFFF, 24'h03FFFF, 24'h555400, 24'hAAABFF, 24'h000200};
		foreach (directed[i])
			send_lookup(directed[i]);

		for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
			if (n >= RANDOM_LOOKUPS - QUIET_TAIL)
				quiet_tail = 1'b1;
			send_lookup(pick_address());
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_ram.sv
hdl/two_level_page_translate.sv
tb/sv/tb_two_level_page_translate.sv
